FILE: hdl/bsat_pkg.sv
// Shared types and constants of the beacon sweep angle tracker.
package bsat_pkg;

    localparam int unsigned DIV_STEPS = 16;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    localparam logic [15:0] SHARE_FULL = 16'hFFFF;

    // Beacon identifiers as they arrive on the hit channel.
    localparam logic [2:0] ID_FRIEND_A = 3'd0;
    localparam logic [2:0] ID_FRIEND_B = 3'd1;
    localparam logic [2:0] ID_FRIEND_C = 3'd2;
    localparam logic [2:0] ID_ENEMY_A  = 3'd3;
    localparam logic [2:0] ID_ENEMY_B  = 3'd4;
    localparam logic [2:0] ID_ENEMY_C  = 3'd5;

    // Position in the sweep, also the code of the last beacon seen.
    localparam logic [1:0] POS_NONE = 2'd0;
    localparam logic [1:0] POS_A    = 2'd1;
    localparam logic [1:0] POS_B    = 2'd2;
    localparam logic [1:0] POS_C    = 2'd3;

    typedef enum logic [1:0] {
        K_NONE,
        K_FRIEND,
        K_ENEMY
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_STEP,
        S_SAVE,
        S_EMIT,
        S_STORE
    } t_state;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_step;
        logic div_save;
        logic div_sel;
        logic emit;
        logic enemy_write;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  out_free;
    } t_stat;

endpackage

FILE: hdl/bsat_if.sv
// Handshake channels of the tracker: beacon hits in, sweep shares out.
interface bsat_hit_if;
    logic        valid;
    logic        ready;
    logic [2:0]  beacon_id;
    logic [15:0] timestamp;

    modport source (output valid, beacon_id, timestamp, input ready);
    modport sink   (input valid, beacon_id, timestamp, output ready);
endinterface

interface bsat_share_if;
    logic        valid;
    logic        ready;
    logic [15:0] friend_first_share;
    logic [15:0] friend_second_share;
    logic [15:0] enemy_first_share;
    logic [15:0] enemy_second_share;
    logic        enemy_valid;

    modport source (output valid, friend_first_share, friend_second_share,
                    enemy_first_share, enemy_second_share, enemy_valid,
                    input ready);
    modport sink   (input valid, friend_first_share, friend_second_share,
                    enemy_first_share, enemy_second_share, enemy_valid,
                    output ready);
endinterface

FILE: hdl/bsat_datapath.sv
// Datapath of the tracker: sweep state, shared restoring divider, output register.
module bsat_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bsat_pkg::t_cmd     i_cmd,
    output bsat_pkg::t_stat    o_stat,
    input  logic [2:0]         i_beacon_id,
    input  logic [15:0]        i_timestamp,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [15:0]        o_friend_first_share,
    output logic [15:0]        o_friend_second_share,
    output logic [15:0]        o_enemy_first_share,
    output logic [15:0]        o_enemy_second_share,
    output logic               o_enemy_valid
);
    import bsat_pkg::*;

    // Sweep state of both sides.
    logic [1:0]  r_f_last, r_e_last;
    logic        r_f_err, r_e_err;
    logic [15:0] r_f_prev_c, r_f_a, r_f_b;
    logic [15:0] r_e_prev_c, r_e_a, r_e_b;
    logic [15:0] r_e_share0, r_e_share1;

    // Divider operands and working registers.
    logic [15:0] r_total, r_diff0, r_diff1;
    logic [15:0] r_rem, r_dlo, r_quo, r_q0, r_q1;
    logic        r_sat;

    // Output register.
    logic        r_out_valid;
    logic [15:0] r_o_f0, r_o_f1, r_o_e0, r_o_e1;
    logic        r_o_ev;

    // Hit decode.
    logic        w_friend, w_enemy;
    logic [1:0]  w_pos, w_last, w_expected;
    logic        w_err, w_err_new, w_dup, w_live;
    logic [15:0] w_prev_c, w_a, w_b;

    always_comb begin
        w_friend = 1'b0;
        w_enemy  = 1'b0;
        w_pos    = POS_NONE;
        unique case (i_beacon_id)
            ID_FRIEND_A: begin w_friend = 1'b1; w_pos = POS_A; end
            ID_FRIEND_B: begin w_friend = 1'b1; w_pos = POS_B; end
            ID_FRIEND_C: begin w_friend = 1'b1; w_pos = POS_C; end
            ID_ENEMY_A:  begin w_enemy  = 1'b1; w_pos = POS_A; end
            ID_ENEMY_B:  begin w_enemy  = 1'b1; w_pos = POS_B; end
            ID_ENEMY_C:  begin w_enemy  = 1'b1; w_pos = POS_C; end
            default:     begin w_pos = POS_NONE; end
        endcase
        w_last     = w_friend ? r_f_last   : r_e_last;
        w_err      = w_friend ? r_f_err    : r_e_err;
        w_prev_c   = w_friend ? r_f_prev_c : r_e_prev_c;
        w_a        = w_friend ? r_f_a      : r_e_a;
        w_b        = w_friend ? r_f_b      : r_e_b;
        w_expected = (w_pos == POS_A) ? POS_C : w_pos - 2'd1;
        w_err_new  = w_err | (w_last != w_expected);
        w_dup      = (w_last == w_pos);
        w_live     = (w_friend | w_enemy) & ~w_dup;
    end

    // A friend C hit with an order error is dropped without any division.
    always_comb begin
        o_stat.kind = K_NONE;
        if (w_live && w_pos == POS_C) begin
            if (w_enemy) begin
                o_stat.kind = K_ENEMY;
            end else if (!w_err_new) begin
                o_stat.kind = K_FRIEND;
            end
        end
        o_stat.out_free = ~r_out_valid | i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_last   <= POS_NONE;
            r_e_last   <= POS_NONE;
            r_f_err    <= 1'b0;
            r_e_err    <= 1'b0;
            r_f_prev_c <= '0;
            r_f_a      <= '0;
            r_f_b      <= '0;
            r_e_prev_c <= '0;
            r_e_a      <= '0;
            r_e_b      <= '0;
            r_e_share0 <= '0;
            r_e_share1 <= '0;
        end else begin
            if (i_cmd.accept && w_live) begin
                if (w_friend) begin
                    r_f_last <= w_pos;
                    // The flag of a friend C hit is consumed by that hit.
                    r_f_err  <= (w_pos == POS_C) ? 1'b0 : w_err_new;
                    if (w_pos == POS_A) r_f_a <= i_timestamp;
                    if (w_pos == POS_B) r_f_b <= i_timestamp;
                    if (w_pos == POS_C) r_f_prev_c <= i_timestamp;
                end else begin
                    r_e_last <= w_pos;
                    r_e_err  <= w_err_new;
                    if (w_pos == POS_A) r_e_a <= i_timestamp;
                    if (w_pos == POS_B) r_e_b <= i_timestamp;
                    if (w_pos == POS_C) r_e_prev_c <= i_timestamp;
                end
            end
            if (i_cmd.emit) begin
                r_e_err <= 1'b0;
            end
            if (i_cmd.enemy_write) begin
                r_e_share0 <= r_q0;
                r_e_share1 <= r_q1;
            end
        end
    end

    // Divider: N = diff * 65535 split as a 32-bit dividend; 16 quotient bits.
    logic [15:0] w_diff;
    logic [31:0] w_num;
    logic [16:0] w_trial, w_sub;
    logic        w_ge;

    always_comb begin
        w_diff  = i_cmd.div_sel ? r_diff1 : r_diff0;
        w_num   = {w_diff, 16'h0000} - {16'h0000, w_diff};
        w_trial = {r_rem, r_dlo[15]};
        w_sub   = w_trial - {1'b0, r_total};
        w_ge    = (w_trial >= {1'b0, r_total});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_total <= i_timestamp - w_prev_c;
            r_diff0 <= w_a - w_prev_c;
            r_diff1 <= w_b - w_a;
        end
        if (i_cmd.div_start) begin
            r_rem <= w_num[31:16];
            r_dlo <= w_num[15:0];
            r_quo <= '0;
            // A share of one or more, or an empty sweep, is full scale.
            r_sat <= (r_total == 16'h0000) || (w_diff >= r_total);
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_sub[15:0] : w_trial[15:0];
            r_dlo <= {r_dlo[14:0], 1'b0};
            r_quo <= {r_quo[14:0], w_ge};
        end
        if (i_cmd.div_save) begin
            if (i_cmd.div_sel) begin
                r_q1 <= r_sat ? SHARE_FULL : r_quo;
            end else begin
                r_q0 <= r_sat ? SHARE_FULL : r_quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_f0 <= r_q0;
            r_o_f1 <= r_q1;
            r_o_e0 <= r_e_err ? 16'h0000 : r_e_share0;
            r_o_e1 <= r_e_err ? 16'h0000 : r_e_share1;
            r_o_ev <= ~r_e_err;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_friend_first_share  = r_o_f0;
    assign o_friend_second_share = r_o_f1;
    assign o_enemy_first_share   = r_o_e0;
    assign o_enemy_second_share  = r_o_e1;
    assign o_enemy_valid         = r_o_ev;

endmodule

FILE: hdl/bsat_ctrl.sv
// Controller of the tracker: sequences acceptance, two divisions and delivery or the enemy store.
module bsat_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  bsat_pkg::t_stat i_stat,
    output bsat_pkg::t_cmd  o_cmd
);
    import bsat_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_sel, n_sel;
    logic             r_enemy, n_enemy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_sel   <= 1'b0;
            r_enemy <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sel   <= n_sel;
            r_enemy <= n_enemy;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_sel      = r_sel;
        n_enemy    = r_enemy;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.div_sel = r_sel;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_stat.kind != K_NONE) begin
                    n_sel   = 1'b0;
                    n_enemy = (i_stat.kind == K_ENEMY);
                    n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.div_start = 1'b1;
                n_cnt   = '0;
                n_state = S_STEP;
            end
            S_STEP: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_SAVE;
                end
            end
            S_SAVE: begin
                o_cmd.div_save = 1'b1;
                if (!r_sel) begin
                    n_sel   = 1'b1;
                    n_state = S_START;
                end else begin
                    n_state = r_enemy ? S_STORE : S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_STORE: begin
                o_cmd.enemy_write = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/beacon_sweep_angle_tracker.sv
// Top level of the beacon sweep angle tracker.
//
// The block takes beacon hits on the i_hit channel, one word per hit with a
// beacon id and a 16-bit timestamp, and delivers sweep shares on the o_share
// channel, one word per accepted friend C hit whose sweep had no order error.
// Both channels move a word at a rising edge where valid and ready are high.
//
// A hits, B hits, repeated beacons, unused ids and a friend C hit that is
// dropped for an order error pass without a stall: ready stays high and the
// next word can follow at once. A friend or enemy C hit runs two 16-bit
// restoring divisions on one shared divider, each a load step, one step per
// quotient bit and a save step, with input ready low until the result is
// emitted or stored. A friend result enters the output register once that
// is free; it is offered on o_share in the cycle after it is loaded.
//
// The output register keeps a result until the receiver takes it, and the
// block keeps accepting hits meanwhile. Only a second friend result waits
// in the controller, with input ready low, until the register is free.
// Synchronous reset clears all sweep state and empties the output register.
module beacon_sweep_angle_tracker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bsat_hit_if.sink     i_hit,
    bsat_share_if.source o_share
);
    import bsat_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    assign i_hit.ready = w_in_ready;

    bsat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_hit.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    bsat_datapath u_datapath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (w_cmd),
        .o_stat                (w_stat),
        .i_beacon_id           (i_hit.beacon_id),
        .i_timestamp           (i_hit.timestamp),
        .i_out_ready           (o_share.ready),
        .o_out_valid           (o_share.valid),
        .o_friend_first_share  (o_share.friend_first_share),
        .o_friend_second_share (o_share.friend_second_share),
        .o_enemy_first_share   (o_share.enemy_first_share),
        .o_enemy_second_share  (o_share.enemy_second_share),
        .o_enemy_valid         (o_share.enemy_valid)
    );

    // A C hit that starts a division holds off the next word.
    a_busy_after_c: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.accept && w_stat.kind != K_NONE) |=> !i_hit.ready)
        else $error("input accepted while a division was starting");

    // A result loaded into the output register is offered in the next cycle.
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> o_share.valid)
        else $error("emitted result not offered on the output");

    // An invalid enemy sweep carries zero shares.
    a_enemy_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_share.valid && !o_share.enemy_valid) |->
        (o_share.enemy_first_share == 16'h0000 &&
         o_share.enemy_second_share == 16'h0000))
        else $error("enemy shares nonzero while enemy is invalid");

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench of the beacon sweep angle tracker.
`timescale 1ns / 100ps

module tb;
    import bsat_pkg::*;

    // Sides of the field, used as indexes into the tracking state below.
    localparam int unsigned SIDE_FRIEND = 0;
    localparam int unsigned SIDE_ENEMY  = 1;

    // The receiver picks one of these stall patterns for a random stretch.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_SPARSE
    } t_rx_mode;

    // One expected share word, as it should appear on the output channel.
    typedef struct {
        logic [15:0] friend_first;
        logic [15:0] friend_second;
        logic [15:0] enemy_first;
        logic [15:0] enemy_second;
        logic        enemy_valid;
    } t_share_word;

    logic i_clk;
    logic i_rst_n;

    bsat_hit_if   hit_ch ();
    bsat_share_if share_ch ();

    beacon_sweep_angle_tracker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hit   (hit_ch),
        .o_share (share_ch)
    );

    // Our own copy of the sweep state of both sides. It advances on every
    // hit word that the block accepts, in the order the block saw them.
    logic [1:0]  last_pos [2];
    logic        order_err [2];
    logic [15:0] prev_c_ts [2];
    logic [15:0] a_ts [2];
    logic [15:0] b_ts [2];
    logic [15:0] enemy_store [2];

    // Share words that the block owes us, oldest first.
    t_share_word pending_shares [$];

    int unsigned mismatch_count;
    int unsigned hits_accepted;
    int unsigned words_checked;
    int unsigned dropped_sweeps;
    int unsigned enemy_invalid_words;
    int unsigned saturated_shares;

    // Sender pacing: a burst of words, then a random gap of up to gap_max.
    int unsigned burst_left;
    int unsigned gap_max;

    // The free-running timer that the random part stamps its hits with.
    logic [15:0] sweep_clock;

    // Set by a test to make the receiver hold off; the value gives the length of the hold-off.
    int unsigned hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The share of a sweep that one interval takes, scaled to full range.
    // A zero sweep or an interval longer than the sweep gives full range.
    function automatic logic [15:0] scaled_share(input logic [15:0] diff,
                                                 input logic [15:0] span);
        logic [31:0] q;
        if (span == 16'd0)
            return SHARE_FULL;
        q = ({16'd0, diff} * {16'd0, SHARE_FULL}) / {16'd0, span};
        return (q > {16'd0, SHARE_FULL}) ? SHARE_FULL : q[15:0];
    endfunction

    function automatic int unsigned side_of(input logic [2:0] id);
        return (id >= ID_ENEMY_A) ? SIDE_ENEMY : SIDE_FRIEND;
    endfunction

    function automatic logic [1:0] pos_of(input logic [2:0] id);
        return POS_A + 2'(id - ((id >= ID_ENEMY_A) ? ID_ENEMY_A : ID_FRIEND_A));
    endfunction

    function automatic logic [2:0] beacon_of(input int unsigned side,
                                             input logic [1:0] pos);
        return ((side == SIDE_ENEMY) ? ID_ENEMY_A : ID_FRIEND_A) + 3'(pos - POS_A);
    endfunction

    // The beacon that keeps a side in the A, B, C order.
    function automatic logic [2:0] next_in_order(input int unsigned side);
        logic [1:0] pos;
        pos = (last_pos[side] == POS_A) ? POS_B :
              (last_pos[side] == POS_B) ? POS_C : POS_A;
        return beacon_of(side, pos);
    endfunction

    // Advances the sweep state by one accepted hit and queues the share
    // word that a clean friend C hit produces.
    task automatic track_hit(input logic [2:0] id, input logic [15:0] ts);
        int unsigned side;
        logic [1:0]  pos;
        logic [1:0]  prior;
        logic [15:0] span;
        logic [15:0] lead;
        logic [15:0] mid;
        t_share_word w;
        if (id > ID_ENEMY_C)
            return;
        side = side_of(id);
        pos  = pos_of(id);
        // A hit on the beacon seen last is a reflection and is dropped.
        if (last_pos[side] == pos)
            return;
        // Only C before A, A before B and B before C keep the sweep clean.
        prior = (pos == POS_A) ? POS_C : pos - 2'd1;
        if (last_pos[side] != prior)
            order_err[side] = 1'b1;
        last_pos[side] = pos;
        if (pos == POS_A) begin
            a_ts[side] = ts;
            return;
        end
        if (pos == POS_B) begin
            b_ts[side] = ts;
            return;
        end
        // A C hit closes the sweep; all intervals wrap at 16 bits.
        span = ts - prev_c_ts[side];
        lead = scaled_share(16'(a_ts[side] - prev_c_ts[side]), span);
        mid  = scaled_share(16'(b_ts[side] - a_ts[side]), span);
        prev_c_ts[side] = ts;
        if (side == SIDE_ENEMY) begin
            enemy_store[0] = lead;
            enemy_store[1] = mid;
        end else if (order_err[SIDE_FRIEND]) begin
            // A friend sweep out of order yields no word and clears the flag.
            order_err[SIDE_FRIEND] = 1'b0;
            dropped_sweeps++;
        end else begin
            w.friend_first  = lead;
            w.friend_second = mid;
            if (!order_err[SIDE_ENEMY]) begin
                w.enemy_first  = enemy_store[0];
                w.enemy_second = enemy_store[1];
                w.enemy_valid  = 1'b1;
            end else begin
                w.enemy_first  = 16'd0;
                w.enemy_second = 16'd0;
                w.enemy_valid  = 1'b0;
                order_err[SIDE_ENEMY] = 1'b0;
                enemy_invalid_words++;
            end
            saturated_shares += (lead == SHARE_FULL) + (mid == SHARE_FULL);
            pending_shares.push_back(w);
        end
    endtask

    // Offers one hit word and returns at the falling edge after it was
    // taken. It is entered at a falling edge. Between bursts it idles the
    // channel for a random number of cycles.
    task automatic send_hit(input logic [2:0] id, input logic [15:0] ts);
        if (burst_left == 0) begin
            hit_ch.valid = 1'b0;
            repeat ($urandom_range(0, gap_max)) @(negedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        hit_ch.valid     = 1'b1;
        hit_ch.beacon_id = id;
        hit_ch.timestamp = ts;
        do @(posedge i_clk); while (!hit_ch.ready);
        track_hit(id, ts);
        hits_accepted++;
        @(negedge i_clk);
        hit_ch.valid = 1'b0;
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Every share word the block hands over is held against the oldest
    // word still owed.
    always @(posedge i_clk) begin : share_check
        t_share_word want;
        if (i_rst_n && share_ch.valid && share_ch.ready) begin
            if (pending_shares.size() == 0) begin
                $error("share word with none owed: %0d %0d %0d %0d %0d",
                       share_ch.friend_first_share, share_ch.friend_second_share,
                       share_ch.enemy_first_share, share_ch.enemy_second_share,
                       share_ch.enemy_valid);
                mismatch_count++;
            end else begin
                want = pending_shares.pop_front();
                check_field("friend_first_share", want.friend_first,
                            share_ch.friend_first_share);
                check_field("friend_second_share", want.friend_second,
                            share_ch.friend_second_share);
                check_field("enemy_first_share", want.enemy_first,
                            share_ch.enemy_first_share);
                check_field("enemy_second_share", want.enemy_second,
                            share_ch.enemy_second_share);
                check_field("enemy_valid", {15'd0, want.enemy_valid},
                            {15'd0, share_ch.enemy_valid});
                words_checked++;
            end
        end
    end

    // The receiver changes its stall pattern at random intervals, and honors a
    // long hold-off when a test asks for one.
    initial begin : share_receiver
        t_rx_mode    mode;
        int unsigned mode_left;
        int unsigned phase;
        share_ch.ready = 1'b0;
        mode      = RX_OPEN;
        mode_left = 0;
        phase     = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                share_ch.ready = 1'b0;
                repeat (hold_cycles - 1) @(negedge i_clk);
                hold_cycles = 0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(32, 256);
                end
                mode_left--;
                phase++;
                case (mode)
                    RX_OPEN:     share_ch.ready = 1'b1;
                    RX_COIN:     share_ch.ready = 1'($urandom_range(0, 1));
                    RX_PERIODIC: share_ch.ready = (phase % 7) < 4;
                    default:     share_ch.ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Straight out of reset neither side has seen a C, so the first sweep
    // on each side is out of order. Also sends a reflection and the two
    // unused ids.
    task automatic test_order_after_reset();
        send_hit(ID_FRIEND_A, 16'd100);
        send_hit(ID_FRIEND_A, 16'd120);
        send_hit(ID_FRIEND_B, 16'd200);
        send_hit(ID_FRIEND_C, 16'd300);
        send_hit(ID_ENEMY_B, 16'h0000);
        send_hit(3'd6, 16'hFFFF);
        send_hit(3'd7, 16'h0000);
    endtask

    // Corner sweeps: a sweep that wraps the timer, an enemy sweep out of
    // order, a zero-length sweep, an interval longer than its sweep, timer
    // extremes, and an enemy C reflection.
    task automatic test_share_corners();
        send_hit(ID_FRIEND_A, 16'd1000);
        send_hit(ID_FRIEND_B, 16'd5000);
        send_hit(ID_FRIEND_C, 16'h0000);
        send_hit(ID_ENEMY_C, 16'd400);
        send_hit(ID_ENEMY_C, 16'd400);
        send_hit(ID_ENEMY_A, 16'd500);
        send_hit(ID_ENEMY_B, 16'hFFFF);
        send_hit(ID_ENEMY_C, 16'hFFFF);
        send_hit(ID_FRIEND_A, 16'd10);
        send_hit(ID_FRIEND_B, 16'd20);
        send_hit(ID_FRIEND_C, 16'h0000);
        send_hit(ID_FRIEND_C, 16'd9);
        send_hit(ID_FRIEND_A, 16'd50000);
        send_hit(ID_FRIEND_B, 16'd50001);
        send_hit(ID_FRIEND_C, 16'd100);
        send_hit(ID_ENEMY_B, 16'd200);
        send_hit(ID_ENEMY_A, 16'd300);
        send_hit(ID_FRIEND_A, 16'd400);
        send_hit(ID_FRIEND_B, 16'd1000);
        send_hit(ID_FRIEND_C, 16'd2000);
    endtask

    // The receiver stops for a long stretch while clean friend sweeps keep
    // coming back to back, so results pile up and the hit input stalls.
    task automatic test_receiver_hold();
        gap_max     = 0;
        hold_cycles = 400;
        repeat (36) begin
            sweep_clock += 16'($urandom_range(50, 900));
            send_hit(next_in_order(SIDE_FRIEND), sweep_clock);
        end
    endtask

    // Mostly clean interleaved sweeps on both sides, stamped from a running
    // timer that wraps, with reflections, out-of-order hits, unused ids and
    // wild timestamps mixed in. Ignored hits do not count toward the target.
    task automatic test_random_sweeps(input int unsigned target);
        int unsigned counted;
        int unsigned side;
        int unsigned pick;
        int unsigned reach;
        logic [2:0]  id;
        logic [15:0] ts;
        logic        ignored;
        counted = 0;
        while (counted < target) begin
            if ($urandom_range(0, 149) == 0)
                gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
            pick  = $urandom_range(0, 9);
            reach = (pick < 2) ? 30 : (pick < 9) ? 3000 : 65535;
            sweep_clock += 16'($urandom_range(0, reach));
            side = $urandom_range(0, 1);
            pick = $urandom_range(0, 99);
            ts   = sweep_clock;
            if (pick < 76) begin
                id = next_in_order(side);
            end else if (pick < 84) begin
                id = 3'($urandom_range(ID_FRIEND_A, ID_ENEMY_C));
            end else if (pick < 90) begin
                id = (last_pos[side] == POS_NONE) ? next_in_order(side)
                                                  : beacon_of(side, last_pos[side]);
                ts = 16'($urandom);
            end else if (pick < 94) begin
                id = 3'($urandom_range(6, 7));
                ts = 16'($urandom);
            end else begin
                id = next_in_order(side);
                ts = 16'($urandom);
            end
            ignored = (id > ID_ENEMY_C) || (last_pos[side_of(id)] == pos_of(id));
            send_hit(id, ts);
            if (!ignored)
                counted++;
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        hit_ch.valid     = 1'b0;
        hit_ch.beacon_id = ID_FRIEND_A;
        hit_ch.timestamp = 16'd0;
        for (int s = 0; s < 2; s++) begin
            last_pos[s]    = POS_NONE;
            order_err[s]   = 1'b0;
            prev_c_ts[s]   = 16'd0;
            a_ts[s]        = 16'd0;
            b_ts[s]        = 16'd0;
            enemy_store[s] = 16'd0;
        end
        mismatch_count      = 0;
        hits_accepted       = 0;
        words_checked       = 0;
        dropped_sweeps      = 0;
        enemy_invalid_words = 0;
        saturated_shares    = 0;
        burst_left          = 0;
        gap_max             = 6;
        sweep_clock         = 16'd0;
        hold_cycles         = 0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_order_after_reset();
        test_share_corners();
        test_receiver_hold();
        test_random_sweeps(1250);

        // Let the last words drain, then keep watching the output for anything
        // the block should not have sent.
        while (pending_shares.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("Ran %0d beacon hits through reset order, corner sweeps, a long receiver",
                 hits_accepted);
        $display("hold-off and random sweeps: %0d share words checked, %0d dropped, %0d %s%0d",
                 words_checked, dropped_sweeps, enemy_invalid_words,
                 "with the enemy sweep invalid, full-scale friend shares: ",
                 saturated_shares);
        if (mismatch_count == 0 && pending_shares.size() == 0) begin
            $display("PASS beacon_sweep_angle_tracker");
        end else begin
            $display("FAIL beacon_sweep_angle_tracker");
        end
        $finish;
    end

    // Watchdog: many times the slowest run that the stimulus can produce.
    initial begin
        #10ms;
        $display("FAIL beacon_sweep_angle_tracker");
        $finish;
    end

endmodule
